/* rtl/pbs_pkg.sv */
// ----------------------------------------------------------------------------
// pbs_pkg
// Types, constants and helpers for the saturating pixel binning block.
// ----------------------------------------------------------------------------
package pbs_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_BIN_DEF    = 16;
   localparam int PIXEL_BITS_DEF = 16;

   localparam int MAX_HEIGHT     = 4096;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 12;

   localparam int WORD_BITS      = 16;
   localparam int BIN_CFG_BITS   = 5;
   localparam int DIM_CFG_BITS   = 13;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_IDX_BITS   = 2;

   localparam int BIN_RESET      = 1;
   localparam int DIM_RESET      = 4096;

   localparam logic [WORD_BITS-1:0] SAT_MAX = 16'hFFFF;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_BIN_X        = 2'd0,
      CSR_BIN_Y        = 2'd1,
      CSR_IMAGE_WIDTH  = 2'd2,
      CSR_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   function automatic logic [WORD_BITS-1:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_BITS] ? SAT_MAX : s[WORD_BITS-1:0];
   endfunction

endpackage

/* rtl/pixel_binning_saturating.sv */
// ----------------------------------------------------------------------------
// pixel_binning_saturating
// Sums bin_x by bin_y blocks of a raster pixel stream into saturated binned
// pixels, with a line store for the partial sums of one band of columns.
// ----------------------------------------------------------------------------
//
//   port group   direction   word                          handshake
//   req_*        in          pixel                         req_valid / req_stall
//   rsp_*        out         binned_pixel, row/frame end   rsp_valid / rsp_stall
//   csr_*        in          register index, data          csr_wr_en, no wait
//
// One pixel per clock while the input is not stalled; each pixel makes one
// line-store read at accept and at most one write as it leaves stage two. A
// result word is registered as its last pixel leaves stage two. After each
// register write the input stalls while a bit-serial divider derives sizes.
// Reset is synchronous; the line store is not cleared. A stalled result word
// holds and stalls the input only when stage two also holds a bin's last pixel.
// ----------------------------------------------------------------------------
module pixel_binning_saturating #(
   parameter int MAX_WIDTH  = pbs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_BIN    = pbs_pkg::MAX_BIN_DEF,
   parameter int PIXEL_BITS = pbs_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pbs_pkg::WORD_BITS-1:0]      req_pixel,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pbs_pkg::WORD_BITS-1:0]      rsp_binned_pixel,
   output logic                               rsp_row_end,
   output logic                               rsp_frame_end,
   input  logic                               csr_wr_en,
   input  logic [pbs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [pbs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import pbs_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int BW    = $clog2(MAX_BIN + 1);
   localparam int BCW   = $clog2(MAX_BIN);
   localparam int HW    = HEIGHT_BITS;
   localparam int RW    = ROW_BITS;
   localparam int DW    = (WW > HW) ? WW : HW;
   localparam int NW    = $clog2(DW + 1);
   localparam int WCMP  = (WW > DIM_CFG_BITS) ? WW : DIM_CFG_BITS;
   localparam int BCMP  = (BW > BIN_CFG_BITS) ? BW : BIN_CFG_BITS;
   localparam int HCMP  = (HW > DIM_CFG_BITS) ? HW : DIM_CFG_BITS;
   localparam int W_RESET = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;

   // configuration
   logic [BIN_CFG_BITS-1:0] bin_x_ff, bin_y_ff;
   logic [DIM_CFG_BITS-1:0] image_width_ff, image_height_ff;

   // derived-size divider
   logic          start_ff, start_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] nq_w_ff, nq_w_in, nq_h_ff, nq_h_in;
   logic [BW-1:0] rem_w_ff, rem_w_in, rem_h_ff, rem_h_in;
   logic [BW:0]   trial_w, trial_h;
   logic          cfg_busy;

   // clamped and derived sizes
   logic [BW-1:0] bx, by;
   logic [WW-1:0] w, out_w, used_w;
   logic [HW-1:0] h, used_h;

   // stream counters
   logic [WORD_BITS-1:0] run_sum_ff, run_sum_in;
   logic [CW-1:0]        src_column_ff, src_column_in;
   logic [RW-1:0]        src_row_ff, src_row_in;
   logic [BCW-1:0]       column_in_bin_ff, column_in_bin_in;
   logic [BCW-1:0]       row_in_bin_ff, row_in_bin_in;
   logic [CW-1:0]        out_column_ff, out_column_in;

   // first stage decode
   logic                 accept;
   logic [WORD_BITS-1:0] px, run_calc;
   logic                 in_used, last_col, last_row, col_last_bin, row_last_bin;
   logic                 bin_end, emit, row_end, frame_end;

   // second stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_bin_end_ff, s1_emit_ff, s1_first_ff, s1_re_ff, s1_fe_ff;
   logic [WORD_BITS-1:0] s1_run_ff;
   logic [CW-1:0]        s1_idx_ff;
   logic                 s1_fwd_ff, s1_fwd_in;
   logic [WORD_BITS-1:0] s1_fwd_data_ff;
   logic [WORD_BITS-1:0] rd_ff, prev, total;
   logic                 s1_go, mem_wr;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_pixel_ff;
   logic                 rsp_re_ff, rsp_fe_ff;

   logic [WORD_BITS-1:0] band_mem [MAX_WIDTH];

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_x_ff        <= BIN_CFG_BITS'(BIN_RESET);
         bin_y_ff        <= BIN_CFG_BITS'(BIN_RESET);
         image_width_ff  <= DIM_CFG_BITS'(DIM_RESET);
         image_height_ff <= DIM_CFG_BITS'(DIM_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIN_X:        bin_x_ff        <= csr_wdata[BIN_CFG_BITS-1:0];
            CSR_BIN_Y:        bin_y_ff        <= csr_wdata[BIN_CFG_BITS-1:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[DIM_CFG_BITS-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[DIM_CFG_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      if (bin_x_ff == '0) begin
         bx = BW'(1);
      end else if (BCMP'(bin_x_ff) > BCMP'(MAX_BIN)) begin
         bx = BW'(MAX_BIN);
      end else begin
         bx = BW'(bin_x_ff);
      end
      if (bin_y_ff == '0) begin
         by = BW'(1);
      end else if (BCMP'(bin_y_ff) > BCMP'(MAX_BIN)) begin
         by = BW'(MAX_BIN);
      end else begin
         by = BW'(bin_y_ff);
      end
      if (image_width_ff == '0) begin
         w = WW'(1);
      end else if (WCMP'(image_width_ff) > WCMP'(MAX_WIDTH)) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h = HW'(1);
      end else if (HCMP'(image_height_ff) > HCMP'(MAX_HEIGHT)) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(image_height_ff);
      end
   end

   // ---------------------------------------------------------------- divider
   assign trial_w = {rem_w_ff, nq_w_ff[DW-1]};
   assign trial_h = {rem_h_ff, nq_h_ff[DW-1]};
   assign cfg_busy = csr_wr_en || start_ff || (cnt_ff != '0);

   always_comb begin
      start_in = csr_wr_en;
      cnt_in   = cnt_ff;
      nq_w_in  = nq_w_ff;
      nq_h_in  = nq_h_ff;
      rem_w_in = rem_w_ff;
      rem_h_in = rem_h_ff;
      if (start_ff) begin
         cnt_in   = NW'(DW);
         nq_w_in  = DW'(w);
         nq_h_in  = DW'(h);
         rem_w_in = '0;
         rem_h_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - NW'(1);
         if (trial_w >= {1'b0, bx}) begin
            rem_w_in = BW'(trial_w - {1'b0, bx});
            nq_w_in  = {nq_w_ff[DW-2:0], 1'b1};
         end else begin
            rem_w_in = trial_w[BW-1:0];
            nq_w_in  = {nq_w_ff[DW-2:0], 1'b0};
         end
         if (trial_h >= {1'b0, by}) begin
            rem_h_in = BW'(trial_h - {1'b0, by});
            nq_h_in  = {nq_h_ff[DW-2:0], 1'b1};
         end else begin
            rem_h_in = trial_h[BW-1:0];
            nq_h_in  = {nq_h_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         cnt_ff   <= '0;
         nq_w_ff  <= DW'(W_RESET);
         nq_h_ff  <= DW'(DIM_RESET);
         rem_w_ff <= '0;
         rem_h_ff <= '0;
      end else begin
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
         nq_w_ff  <= nq_w_in;
         nq_h_ff  <= nq_h_in;
         rem_w_ff <= rem_w_in;
         rem_h_ff <= rem_h_in;
      end
   end

   assign out_w  = WW'(nq_w_ff);
   assign used_w = w - WW'(rem_w_ff);
   assign used_h = h - HW'(rem_h_ff);

   // ---------------------------------------------------------------- first stage
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = cfg_busy || (s1_valid_ff && !s1_go);
   assign accept    = req_valid && !req_stall;

   assign px           = WORD_BITS'(req_pixel[PIXEL_BITS-1:0]);
   assign in_used      = (WW'(src_column_ff) < used_w) && (HW'(src_row_ff) < used_h);
   assign last_col     = (WW'(src_column_ff) + WW'(1)) >= w;
   assign last_row     = (HW'(src_row_ff) + HW'(1)) >= h;
   assign col_last_bin = (BW'(column_in_bin_ff) + BW'(1)) >= bx;
   assign row_last_bin = (BW'(row_in_bin_ff) + BW'(1)) >= by;
   assign bin_end      = in_used && col_last_bin;
   assign emit         = bin_end && row_last_bin;
   assign row_end      = (WW'(out_column_ff) + WW'(1)) >= out_w;
   assign frame_end    = row_end && ((HW'(src_row_ff) + HW'(1)) >= used_h);
   assign run_calc     = (column_in_bin_ff == '0) ? px : sat_add(run_sum_ff, px);

   always_comb begin
      run_sum_in       = run_sum_ff;
      src_column_in    = src_column_ff;
      src_row_in       = src_row_ff;
      column_in_bin_in = column_in_bin_ff;
      row_in_bin_in    = row_in_bin_ff;
      out_column_in    = out_column_ff;
      if (accept) begin
         if (in_used) begin
            run_sum_in = run_calc;
            if (col_last_bin) begin
               column_in_bin_in = '0;
               out_column_in    = out_column_ff + CW'(1);
            end else begin
               column_in_bin_in = column_in_bin_ff + BCW'(1);
            end
         end
         if (last_col) begin
            src_column_in    = '0;
            column_in_bin_in = '0;
            out_column_in    = '0;
            run_sum_in       = '0;
            if (last_row) begin
               src_row_in    = '0;
               row_in_bin_in = '0;
            end else begin
               src_row_in    = src_row_ff + RW'(1);
               row_in_bin_in = row_last_bin ? '0 : row_in_bin_ff + BCW'(1);
            end
         end else begin
            src_column_in = src_column_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff       <= '0;
         src_column_ff    <= '0;
         src_row_ff       <= '0;
         column_in_bin_ff <= '0;
         row_in_bin_ff    <= '0;
         out_column_ff    <= '0;
      end else begin
         run_sum_ff       <= run_sum_in;
         src_column_ff    <= src_column_in;
         src_row_ff       <= src_row_in;
         column_in_bin_ff <= column_in_bin_in;
         row_in_bin_ff    <= row_in_bin_in;
         out_column_ff    <= out_column_in;
      end
   end

   // ---------------------------------------------------------------- second stage
   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign s1_fwd_in   = s1_go && s1_bin_end_ff && !s1_emit_ff && (s1_idx_ff == out_column_ff);
   assign prev        = s1_first_ff ? '0 : (s1_fwd_ff ? s1_fwd_data_ff : rd_ff);
   assign total       = sat_add(s1_run_ff, prev);
   assign mem_wr      = s1_go && s1_bin_end_ff && !s1_emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bin_end_ff  <= bin_end;
         s1_emit_ff     <= emit;
         s1_first_ff    <= (row_in_bin_ff == '0);
         s1_re_ff       <= row_end;
         s1_fe_ff       <= frame_end;
         s1_run_ff      <= run_calc;
         s1_idx_ff      <= out_column_ff;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= total;
      end
   end

   // line store: read at accept, write as the bin's partial sum leaves stage two
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= band_mem[out_column_ff];
      end
      if (mem_wr) begin
         band_mem[s1_idx_ff] <= total;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      if (s1_go && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_pixel_ff <= total;
         rsp_re_ff    <= s1_re_ff;
         rsp_fe_ff    <= s1_fe_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binned_pixel = rsp_pixel_ff;
   assign rsp_row_end      = rsp_re_ff;
   assign rsp_frame_end    = rsp_fe_ff;

endmodule
